[rtl/bfss_pkg.sv]
// Shared types and constants for the byte FIFO with separator search.
`timescale 1ns / 1ps
`default_nettype none

package bfss_pkg;

    localparam int STORE_DEPTH_DEFAULT   = 4096;
    localparam int MAX_SEPARATOR_DEFAULT = 8;
    localparam int DRAIN_LIMIT           = 64;
    localparam int SEP_BYTES             = 8;
    localparam int POS_W                 = 13;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_DRAIN  = 2'd1,
        OP_FIND   = 2'd2,
        OP_LENGTH = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_SHORT     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CFG_SEP_BYTES  = 1'b0,
        CFG_SEP_LENGTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PUSH,
        CMD_DRAIN_LOAD,
        CMD_DRAIN_STEP,
        CMD_FIND_LOAD,
        CMD_FIND_READ,
        CMD_FIND_CMP
    } cmd_op_t;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_COUNT,
        POS_FIND
    } pos_sel_t;

    typedef struct packed {
        cmd_op_t  op;
        logic     reply;
        status_t  reply_status;
        pos_sel_t reply_pos;
    } ctl_cmd_t;

    typedef struct packed {
        logic full;
        logic drain_zero;
        logic drain_ok;
        logic drain_last;
        logic find_reject;
        logic find_hit;
        logic find_exhausted;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/bfss_ctrl.sv]
// Controller state machine of the byte FIFO with separator search.
`timescale 1ns / 1ps
`default_nettype none

module bfss_ctrl
    import bfss_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] opcode,
    input  wire dp_status_t dp_status,
    output ctl_cmd_t        cmd,
    output logic            busy
);

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_DRAIN    = 4'b0010,
        S_FIND_RD  = 4'b0100,
        S_FIND_CMP = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        cmd.op           = CMD_NONE;
        cmd.reply        = 1'b0;
        cmd.reply_status = ST_OK;
        cmd.reply_pos    = POS_ZERO;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode_t'(opcode))
                        OP_PUSH:
                        begin
                            cmd.reply = 1'b1;
                            if (dp_status.full)
                            begin
                                cmd.reply_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.op = CMD_PUSH;
                            end
                        end
                        OP_DRAIN:
                        begin
                            if (dp_status.drain_zero)
                            begin
                                cmd.reply = 1'b1;
                            end
                            else if (!dp_status.drain_ok)
                            begin
                                cmd.reply        = 1'b1;
                                cmd.reply_status = ST_SHORT;
                            end
                            else
                            begin
                                cmd.op     = CMD_DRAIN_LOAD;
                                state_next = S_DRAIN;
                            end
                        end
                        OP_FIND:
                        begin
                            if (dp_status.find_reject)
                            begin
                                cmd.reply        = 1'b1;
                                cmd.reply_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                cmd.op     = CMD_FIND_LOAD;
                                state_next = S_FIND_RD;
                            end
                        end
                        OP_LENGTH:
                        begin
                            cmd.reply     = 1'b1;
                            cmd.reply_pos = POS_COUNT;
                        end
                        default:
                        begin
                            cmd.op = CMD_NONE;
                        end
                    endcase
                end
            end
            S_DRAIN:
            begin
                cmd.op = CMD_DRAIN_STEP;
                if (dp_status.drain_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FIND_RD:
            begin
                cmd.op     = CMD_FIND_READ;
                state_next = S_FIND_CMP;
            end
            S_FIND_CMP:
            begin
                cmd.op = CMD_FIND_CMP;
                if (dp_status.find_hit)
                begin
                    cmd.reply     = 1'b1;
                    cmd.reply_pos = POS_FIND;
                    state_next    = S_IDLE;
                end
                else if (dp_status.find_exhausted)
                begin
                    cmd.reply        = 1'b1;
                    cmd.reply_status = ST_NOT_FOUND;
                    state_next       = S_IDLE;
                end
                else
                begin
                    state_next = S_FIND_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/bfss_datapath.sv]
// Datapath of the byte FIFO: byte store, pointers, separator compare and result register.
`timescale 1ns / 1ps
`default_nettype none

module bfss_datapath
    import bfss_pkg::*;
#(
    parameter int STORE_DEPTH   = STORE_DEPTH_DEFAULT,
    parameter int MAX_SEPARATOR = MAX_SEPARATOR_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ctl_cmd_t         cmd,
    input  wire logic [7:0]       push_byte,
    input  wire logic [6:0]       drain_count,
    input  wire logic             cfg_valid,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [63:0]      cfg_data,
    output dp_status_t            dp_status,
    output logic                  strobe,
    output logic [7:0]            out_byte,
    output logic [POS_W-1:0]      position,
    output logic [1:0]            status,
    output logic                  last
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int MW = (SW > 8) ? SW : 8;

    logic [7:0]    mem [STORE_DEPTH];
    logic [7:0]    q_reg;
    logic [AW-1:0] rd_addr;

    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [6:0]    remain_reg;
    logic [CW-1:0] find_i_reg;
    logic [2:0]    find_j_reg;
    logic [3:0]    find_len_reg;

    logic [63:0]   sep_bytes_reg;
    logic [3:0]    sep_len_reg;

    logic             emit_reg, emit_last_reg;
    logic             reply_reg;
    status_t          reply_status_reg;
    logic [POS_W-1:0] reply_pos_reg;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(STORE_DEPTH))
        begin
            sum = sum - SW'(STORE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [MW-1:0] count_w, len_w, dc_w, i_w;
    logic [CW-1:0] find_off;
    logic          byte_match, j_is_final;

    assign count_w    = MW'(count_reg);
    assign len_w      = MW'(find_len_reg);
    assign dc_w       = MW'(drain_count);
    assign i_w        = MW'(find_i_reg);
    assign find_off   = find_i_reg + CW'(find_j_reg);
    assign byte_match = (q_reg == sep_bytes_reg[8*find_j_reg +: 8]);
    assign j_is_final = ({1'b0, find_j_reg} == (find_len_reg - 4'd1));

    always_comb
    begin
        dp_status.full        = (count_w == MW'(STORE_DEPTH));
        dp_status.drain_zero  = (drain_count == 7'd0);
        dp_status.drain_ok    = (drain_count <= 7'(DRAIN_LIMIT)) && (dc_w <= count_w);
        dp_status.drain_last  = (remain_reg == 7'd1);
        dp_status.find_reject = (count_reg == '0) || (sep_len_reg == 4'd0)
                                || (32'(sep_len_reg) > MAX_SEPARATOR)
                                || (sep_len_reg > 4'(SEP_BYTES))
                                || (MW'(sep_len_reg) > count_w);
        dp_status.find_hit    = byte_match && j_is_final;
        dp_status.find_exhausted = !byte_match && ((i_w + MW'(1) + len_w) > count_w);
    end

    always_comb
    begin
        if (cmd.op == CMD_FIND_READ)
        begin
            rd_addr = wrap_add(head_reg, find_off);
        end
        else
        begin
            rd_addr = head_reg;
        end
    end

    // Byte store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_PUSH)
        begin
            mem[wrap_add(head_reg, count_reg)] <= push_byte;
        end
        q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            remain_reg    <= '0;
            sep_bytes_reg <= 64'd10;
            sep_len_reg   <= 4'd1;
            emit_reg      <= 1'b0;
            emit_last_reg <= 1'b0;
            reply_reg     <= 1'b0;
        end
        else
        begin
            emit_reg  <= 1'b0;
            reply_reg <= cmd.reply;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    2'(CFG_SEP_BYTES):  sep_bytes_reg <= cfg_data;
                    2'(CFG_SEP_LENGTH): sep_len_reg   <= cfg_data[3:0];
                    default:            sep_len_reg   <= sep_len_reg;
                endcase
            end
            case (cmd.op)
                CMD_PUSH:
                begin
                    count_reg <= count_reg + CW'(1);
                end
                CMD_DRAIN_LOAD:
                begin
                    remain_reg <= drain_count;
                end
                CMD_DRAIN_STEP:
                begin
                    head_reg      <= wrap_add(head_reg, CW'(1));
                    count_reg     <= count_reg - CW'(1);
                    remain_reg    <= remain_reg - 7'd1;
                    emit_reg      <= 1'b1;
                    emit_last_reg <= (remain_reg == 7'd1);
                end
                default:
                begin
                    remain_reg <= remain_reg;
                end
            endcase
        end
    end

    // Find scan counters and the reply payload.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_FIND_LOAD:
            begin
                find_i_reg   <= '0;
                find_j_reg   <= '0;
                find_len_reg <= sep_len_reg;
            end
            CMD_FIND_CMP:
            begin
                if (byte_match)
                begin
                    find_j_reg <= find_j_reg + 3'd1;
                end
                else
                begin
                    find_i_reg <= find_i_reg + CW'(1);
                    find_j_reg <= '0;
                end
            end
            default:
            begin
                find_j_reg <= find_j_reg;
            end
        endcase
        if (cmd.reply)
        begin
            reply_status_reg <= cmd.reply_status;
            case (cmd.reply_pos)
                POS_COUNT: reply_pos_reg <= POS_W'(count_reg);
                POS_FIND:  reply_pos_reg <= POS_W'(i_w + len_w);
                default:   reply_pos_reg <= '0;
            endcase
        end
    end

    assign strobe   = emit_reg | reply_reg;
    assign out_byte = emit_reg ? q_reg : 8'd0;
    assign position = reply_reg ? reply_pos_reg : '0;
    assign status   = reply_reg ? reply_status_reg : ST_OK;
    assign last     = emit_reg ? emit_last_reg : reply_reg;

endmodule

`default_nettype wire

[rtl/byte_fifo_separator_search_unit.sv]
// Top level of the byte FIFO with separator search.
`timescale 1ns / 1ps
`default_nettype none

// A byte FIFO driven by four commands. A command is taken when start is high
// and busy is low. Every result appears for exactly one cycle with strobe high
// and cannot be held off. A push, a length request and any refused command
// answer in the cycle after the transaction. A drain of N bytes delivers one
// byte per cycle, the first after the drain state and the registered store read,
// the final byte marked by last; busy drops while that final byte
// is shown, so the next command may follow at once. A find walks the store
// from the head with one read of the single store port per compared byte,
// each compare an address state followed by a registered-data state.
// Configuration writes are always ready and take effect at once; they must
// only be made while no command is in progress. The store needs no clearing
// after reset.

module byte_fifo_separator_search_unit
    import bfss_pkg::*;
#(
    parameter int STORE_DEPTH   = STORE_DEPTH_DEFAULT,
    parameter int MAX_SEPARATOR = MAX_SEPARATOR_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       opcode,
    input  wire logic [7:0]       push_byte,
    input  wire logic [6:0]       drain_count,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [63:0]      cfg_data,
    output logic                  strobe,
    output logic [7:0]            out_byte,
    output logic [POS_W-1:0]      position,
    output logic [1:0]            status,
    output logic                  last
);

    ctl_cmd_t   cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    // The controller sequences each command; the datapath owns the byte store and its registers.
    bfss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .dp_status (dp_status),
        .cmd       (cmd),
        .busy      (busy)
    );

    bfss_datapath #(
        .STORE_DEPTH   (STORE_DEPTH),
        .MAX_SEPARATOR (MAX_SEPARATOR)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .push_byte   (push_byte),
        .drain_count (drain_count),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .dp_status   (dp_status),
        .strobe      (strobe),
        .out_byte    (out_byte),
        .position    (position),
        .status      (status),
        .last        (last)
    );

endmodule

`default_nettype wire

[rtl/bfss_checker.sv]
// Port-level checks of the byte FIFO with separator search, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bfss_checker
    import bfss_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic [1:0]       opcode,
    input wire logic             strobe,
    input wire logic [7:0]       out_byte,
    input wire logic [POS_W-1:0] position,
    input wire logic [1:0]       status,
    input wire logic             last
);

    // A push or a length request answers with one final result next cycle.
    a_single_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_PUSH || opcode == OP_LENGTH)) |=> (strobe && last))
        else $error("single-result command did not answer next cycle");

    // Refusals and errors are always the only result of their command.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status != ST_OK) |-> (last && out_byte == 8'd0 && position == '0))
        else $error("error result not final or carries payload");

    // Quiet result ports between results.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !strobe |-> (out_byte == 8'd0 && position == '0 && !last))
        else $error("result ports active without strobe");

    // A transaction that leaves the unit idle must have produced a result.
    a_done_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (busy ##1 !busy) |-> (strobe && last))
        else $error("command finished without a final result");

endmodule

bind byte_fifo_separator_search_unit bfss_checker u_bfss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .opcode   (opcode),
    .strobe   (strobe),
    .out_byte (out_byte),
    .position (position),
    .status   (status),
    .last     (last)
);

`default_nettype wire
